[hw/rtl/ckip_pkg.sv]
package ckip_pkg;

    localparam int MAX_DIMS = 4;
    localparam int ID_BITS  = 32;
    localparam int CHAR_W   = 8;
    localparam int DIM_W    = 2;
    localparam int COUNT_W  = 3;
    localparam int INDEX_W  = 3;

    localparam logic [CHAR_W-1:0] CHAR_ZERO     = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE     = 8'h39;
    localparam logic [CHAR_W-1:0] SEPARATOR_RST = 8'h2E;
    localparam logic [COUNT_W-1:0] DIM_COUNT_RST = 3'd1;
    localparam logic [ID_BITS-1:0] BOUND_RST    = 32'd1;

    typedef enum logic [INDEX_W-1:0] {
        REG_SEPARATOR = 3'd0,
        REG_DIM_COUNT = 3'd1,
        REG_BOUND0    = 3'd2,
        REG_BOUND1    = 3'd3,
        REG_BOUND2    = 3'd4,
        REG_BOUND3    = 3'd5
    } cfg_reg_t;

    typedef logic [MAX_DIMS-1:0][ID_BITS-1:0] id_array_t;

    // Outcome of a key, valid in the cycle its final beat is parsed.
    typedef struct packed {
        logic                rejected;
        logic [COUNT_W-1:0]  count;
        id_array_t           ids;
    } key_summary_t;

endpackage

[hw/rtl/ckip_key_if.sv]
interface ckip_key_if;
    logic                          valid;
    logic                          ready;
    logic [ckip_pkg::CHAR_W-1:0]   key_char;
    logic                          key_end;

    modport source (output valid, output key_char, output key_end, input ready);
    modport sink   (input valid, input key_char, input key_end, output ready);
endinterface

[hw/rtl/ckip_res_if.sv]
interface ckip_res_if;
    logic                          valid;
    logic                          ready;
    logic [ckip_pkg::ID_BITS-1:0]  chunk_index;
    logic [ckip_pkg::DIM_W-1:0]    dim_position;
    logic                          rejected;
    logic                          run_end;

    modport source (output valid, output chunk_index, output dim_position,
                    output rejected, output run_end, input ready);
    modport sink   (input valid, input chunk_index, input dim_position,
                    input rejected, input run_end, output ready);
endinterface

[hw/rtl/ckip_parser.sv]
module ckip_parser (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              step,
    input  logic [ckip_pkg::CHAR_W-1:0]       key_char,
    input  logic                              key_end,
    input  logic [ckip_pkg::CHAR_W-1:0]       separator_char,
    input  logic [ckip_pkg::COUNT_W-1:0]      dim_count,
    input  ckip_pkg::id_array_t               bounds,
    output ckip_pkg::key_summary_t            summary
);

    logic [ckip_pkg::COUNT_W-1:0]  field_count_reg, field_count_next;
    logic [ckip_pkg::ID_BITS-1:0]  digit_accum_reg, digit_accum_next;
    logic                          digits_seen_reg, digits_seen_next;
    logic                          error_seen_reg, error_seen_next;
    ckip_pkg::id_array_t           id_store_reg, id_store_next;

    logic                          is_digit;
    logic [3:0]                    digit;
    logic [ckip_pkg::ID_BITS+3:0]  scaled;
    logic                          overflow;
    logic                          close_req;
    logic [ckip_pkg::ID_BITS-1:0]  close_val;
    logic [ckip_pkg::DIM_W-1:0]    slot;

    assign is_digit = (key_char >= ckip_pkg::CHAR_ZERO) && (key_char <= ckip_pkg::CHAR_NINE);
    assign digit    = 4'(key_char - ckip_pkg::CHAR_ZERO);
    // accum * 10 + digit as two shifted adds; anything above the id width overflows.
    assign scaled   = {1'b0, digit_accum_reg, 3'b000} + {3'b000, digit_accum_reg, 1'b0}
                      + {{(ckip_pkg::ID_BITS){1'b0}}, digit};
    assign overflow = |scaled[ckip_pkg::ID_BITS+3:ckip_pkg::ID_BITS];
    assign slot     = field_count_reg[ckip_pkg::DIM_W-1:0];

    always_comb
    begin
        field_count_next = field_count_reg;
        digit_accum_next = digit_accum_reg;
        digits_seen_next = digits_seen_reg;
        error_seen_next  = error_seen_reg;
        id_store_next    = id_store_reg;
        close_req        = 1'b0;
        close_val        = digit_accum_reg;

        if (step && !error_seen_reg)
        begin
            if (is_digit)
            begin
                if (overflow)
                begin
                    error_seen_next = 1'b1;
                end
                else
                begin
                    digit_accum_next = scaled[ckip_pkg::ID_BITS-1:0];
                    digits_seen_next = 1'b1;
                    close_req        = key_end;
                    close_val        = scaled[ckip_pkg::ID_BITS-1:0];
                end
            end
            else if (key_char == separator_char)
            begin
                if (!digits_seen_reg)
                    error_seen_next = 1'b1;
                else
                    close_req = 1'b1;
            end
            else
            begin
                error_seen_next = 1'b1;
            end
        end

        if (close_req)
        begin
            if ((field_count_reg >= dim_count) ||
                (field_count_reg >= ckip_pkg::COUNT_W'(ckip_pkg::MAX_DIMS)))
            begin
                error_seen_next = 1'b1;
            end
            else if (close_val >= bounds[slot])
            begin
                error_seen_next = 1'b1;
            end
            else
            begin
                id_store_next[slot] = close_val;
                field_count_next    = field_count_reg + 3'd1;
                digit_accum_next    = '0;
                digits_seen_next    = 1'b0;
            end
        end
    end

    assign summary.rejected = error_seen_next || (field_count_next == '0) ||
                              (field_count_next != dim_count);
    assign summary.count    = field_count_next;
    assign summary.ids      = id_store_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_count_reg <= '0;
            digit_accum_reg <= '0;
            digits_seen_reg <= 1'b0;
            error_seen_reg  <= 1'b0;
        end
        else if (step && key_end)
        begin
            field_count_reg <= '0;
            digit_accum_reg <= '0;
            digits_seen_reg <= 1'b0;
            error_seen_reg  <= 1'b0;
        end
        else
        begin
            field_count_reg <= field_count_next;
            digit_accum_reg <= digit_accum_next;
            digits_seen_reg <= digits_seen_next;
            error_seen_reg  <= error_seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_store_reg <= id_store_next;
    end

endmodule

[hw/rtl/chunk_key_index_parser.sv]
// Chunk key index parser.
// The key channel carries one key byte per beat, with key_end set on the final
// byte. Each key gives either its field ids in reverse key order (dim_position 0
// is the last field, run_end on the final one) or a single beat with rejected
// and run_end set. Configuration is written through cfg_we/cfg_index/cfg_data
// and must only change while the block is idle.
// A byte is registered at the input and parsed from that register; the first
// result beat of a key passes through the snapshot and then the output register.
// Throughput: one key byte per cycle. The result side drains one beat per cycle
// from a snapshot of the key, so the next key is parsed meanwhile; only its
// final byte waits until the previous key's last result moves into the output
// register. An accepted key with N fields thus yields N result beats.
// A stalled receiver holds the output register, then the snapshot, then the
// input register, and finally drops ready on the key channel.
// Reset clears the parse state and all handshake state and sets the registers
// to separator '.', one dimension and chunk counts of one.
module chunk_key_index_parser (
    input  logic                               clk,
    input  logic                               rst_n,
    ckip_key_if.sink                           key,
    ckip_res_if.source                         result,
    input  logic                               cfg_we,
    input  logic [ckip_pkg::INDEX_W-1:0]       cfg_index,
    input  logic [ckip_pkg::ID_BITS-1:0]       cfg_data
);

    logic [ckip_pkg::CHAR_W-1:0]   separator_reg;
    logic [ckip_pkg::COUNT_W-1:0]  dim_count_reg;
    ckip_pkg::id_array_t           bounds_reg;

    logic                          in_valid_reg;
    logic [ckip_pkg::CHAR_W-1:0]   in_char_reg;
    logic                          in_end_reg;
    logic                          consume;

    ckip_pkg::key_summary_t        summary;

    logic                          emit_busy_reg;
    logic                          emit_rej_reg;
    logic [ckip_pkg::COUNT_W-1:0]  emit_cnt_reg;
    logic [ckip_pkg::DIM_W-1:0]    emit_k_reg;
    ckip_pkg::id_array_t           emit_ids_reg;
    logic                          emit_load;
    logic                          emit_last;
    logic [ckip_pkg::DIM_W-1:0]    emit_src;

    logic                          out_valid_reg;
    logic [ckip_pkg::ID_BITS-1:0]  out_index_reg;
    logic [ckip_pkg::DIM_W-1:0]    out_pos_reg;
    logic                          out_rej_reg;
    logic                          out_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            separator_reg <= ckip_pkg::SEPARATOR_RST;
            dim_count_reg <= ckip_pkg::DIM_COUNT_RST;
            bounds_reg    <= {ckip_pkg::MAX_DIMS{ckip_pkg::BOUND_RST}};
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ckip_pkg::REG_SEPARATOR: separator_reg <= cfg_data[ckip_pkg::CHAR_W-1:0];
                ckip_pkg::REG_DIM_COUNT: dim_count_reg <= cfg_data[ckip_pkg::COUNT_W-1:0];
                ckip_pkg::REG_BOUND0:    bounds_reg[0] <= cfg_data;
                ckip_pkg::REG_BOUND1:    bounds_reg[1] <= cfg_data;
                ckip_pkg::REG_BOUND2:    bounds_reg[2] <= cfg_data;
                ckip_pkg::REG_BOUND3:    bounds_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // A final byte is parsed only once the snapshot is free for its results,
    // which includes the cycle in which the last pending beat leaves it.
    assign consume   = in_valid_reg &&
                       (!in_end_reg || !emit_busy_reg || (emit_load && emit_last));
    assign key.ready = !in_valid_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (key.ready)
            in_valid_reg <= key.valid;
    end

    always_ff @(posedge clk)
    begin
        if (key.ready && key.valid)
        begin
            in_char_reg <= key.key_char;
            in_end_reg  <= key.key_end;
        end
    end

    ckip_parser u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (consume),
        .key_char       (in_char_reg),
        .key_end        (in_end_reg),
        .separator_char (separator_reg),
        .dim_count      (dim_count_reg),
        .bounds         (bounds_reg),
        .summary        (summary)
    );

    assign emit_load = emit_busy_reg && (!out_valid_reg || result.ready);
    assign emit_last = emit_rej_reg ||
                       (ckip_pkg::COUNT_W'(emit_k_reg) == emit_cnt_reg - 3'd1);
    assign emit_src  = ckip_pkg::DIM_W'(emit_cnt_reg - 3'd1 - ckip_pkg::COUNT_W'(emit_k_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_busy_reg <= 1'b0;
            emit_k_reg    <= '0;
        end
        else if (consume && in_end_reg)
        begin
            emit_busy_reg <= 1'b1;
            emit_k_reg    <= '0;
        end
        else if (emit_load)
        begin
            emit_busy_reg <= !emit_last;
            emit_k_reg    <= emit_k_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume && in_end_reg)
        begin
            emit_rej_reg <= summary.rejected;
            emit_cnt_reg <= summary.count;
            emit_ids_reg <= summary.ids;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit_load)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            out_index_reg <= emit_rej_reg ? '0 : emit_ids_reg[emit_src];
            out_pos_reg   <= emit_rej_reg ? '0 : emit_k_reg;
            out_rej_reg   <= emit_rej_reg;
            out_end_reg   <= emit_last;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.chunk_index  = out_index_reg;
    assign result.dim_position = out_pos_reg;
    assign result.rejected     = out_rej_reg;
    assign result.run_end      = out_end_reg;

endmodule
